>>> rtl/core/two_link_leg_inverse_kinematics_defines.svh
// Assertion macros shared by the two-link leg IK RTL.
// No dependencies; included by files that carry assertions.
`ifndef TWO_LINK_LEG_INVERSE_KINEMATICS_DEFINES_SVH
`define TWO_LINK_LEG_INVERSE_KINEMATICS_DEFINES_SVH

// Same-cycle implication, disabled during reset
`define TLIK_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("tlik assertion failed");

// Next-cycle implication, disabled during reset
`define TLIK_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("tlik assertion failed");

`endif

>>> rtl/core/tlik_pkg.sv
// Package for the two-link leg IK block: widths, angle constants, arctan table.
// No dependencies.
`default_nettype none
package tlik_pkg;

    localparam int LEN_W        = 14;
    localparam int POS_W        = 15;
    localparam int ANG_OUT_W    = 16;
    localparam int NUM_W        = 31;   // law-of-cosines numerators
    localparam int H_W          = 60;   // radicand
    localparam int SQRT_BITS    = 30;   // root bits, one per stage
    localparam int CW           = 50;   // CORDIC datapath
    localparam int AW           = 24;   // internal angle, 2^-14 degree
    localparam int SUM_W        = 26;
    localparam int CORDIC_STEPS = 16;
    localparam int ATAN_LEN     = 24;
    localparam int CORDIC_N     = (CORDIC_STEPS > ATAN_LEN) ? ATAN_LEN : CORDIC_STEPS;
    localparam int CORDIC_LAT   = CORDIC_N + 1;
    localparam int FRONT_LAT    = 5;

    localparam logic signed [AW-1:0] ANG_DEG90  = 24'sd1474560;
    localparam logic signed [AW-1:0] ANG_DEG180 = 24'sd2949120;

    localparam logic [LEN_W-1:0] LEN_RESET = 14'd1280;

    typedef enum logic {
        REG_THIGH = 1'b0,
        REG_SHIN  = 1'b1
    } t_reg_idx;

    // side data that travels next to the square root
    typedef struct packed {
        logic                    bad;
        logic signed [POS_W-1:0] x;
        logic signed [POS_W-1:0] z;
        logic signed [NUM_W-1:0] a1;
        logic signed [NUM_W-1:0] a2;
        logic signed [NUM_W-1:0] a3;
    } t_side;

    // atan(2^-i) in 2^-14 degree, rounded
    function automatic logic signed [AW-1:0] atan_tab(input int i);
        logic signed [AW-1:0] v;
        begin
            case (i)
                0: v = 24'sd737280;
                1: v = 24'sd435242;
                2: v = 24'sd229970;
                3: v = 24'sd116736;
                4: v = 24'sd58595;
                5: v = 24'sd29326;
                6: v = 24'sd14667;
                7: v = 24'sd7334;
                8: v = 24'sd3667;
                9: v = 24'sd1833;
                10: v = 24'sd917;
                11: v = 24'sd458;
                12: v = 24'sd229;
                13: v = 24'sd115;
                14: v = 24'sd57;
                15: v = 24'sd29;
                16: v = 24'sd14;
                17: v = 24'sd7;
                18: v = 24'sd4;
                19: v = 24'sd2;
                20: v = 24'sd1;
                default: v = '0;
            endcase
            return v;
        end
    endfunction

endpackage
`default_nettype wire

>>> rtl/core/tlik_front.sv
// Front pipeline: squares, law-of-cosines numerators, radicand (5 stages).
// Depends on tlik_pkg.
`default_nettype none
module tlik_front
    import tlik_pkg::*;
(
    input  wire                     i_clk,
    input  wire                     i_rst_n,
    input  wire                     i_valid,
    input  wire signed [POS_W-1:0]  i_x,
    input  wire signed [POS_W-1:0]  i_z,
    input  wire        [LEN_W-1:0]  i_l1,
    input  wire        [LEN_W-1:0]  i_l2,
    output logic                    o_valid,
    output t_side                   o_side,
    output logic       [H_W-1:0]    o_h
);

    logic [FRONT_LAT-1:0] r_v;

    logic signed [POS_W-1:0] r1_x, r1_z, r2_x, r2_z, r3_x, r3_z, r4_x, r4_z, r5_x, r5_z;
    logic r1_bad, r2_bad, r3_bad, r4_bad, r5_bad;
    logic [29:0] r1_xx, r1_zz, r2_s, r3_s;
    logic [27:0] r1_l1sq, r1_l2sq, r2_l1sq, r2_l2sq, r3_l1sq;
    logic signed [NUM_W-1:0] r3_a1, r3_a2, r3_a3, r4_a1, r4_a2, r4_a3;
    logic signed [NUM_W-1:0] r5_a1, r5_a2, r5_a3;
    logic [59:0] r4_p, r4_a1sq;
    logic [H_W-1:0] r5_h;

    logic [57:0] n_prod;
    logic signed [61:0] n_a1sq;
    logic signed [60:0] n_h;

    // valid chain
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else begin
            r_v <= {r_v[FRONT_LAT-2:0], i_valid};
        end
    end

    // stage 1: squares
    always_ff @(posedge i_clk) begin
        r1_x    <= i_x;
        r1_z    <= i_z;
        r1_xx   <= 30'(i_x * i_x);
        r1_zz   <= 30'(i_z * i_z);
        r1_l1sq <= 28'(i_l1 * i_l1);
        r1_l2sq <= 28'(i_l2 * i_l2);
        r1_bad  <= (i_z <= 0) || (i_l1 == '0) || (i_l2 == '0);
    end

    // stage 2: hip-to-foot distance squared
    always_ff @(posedge i_clk) begin
        r2_x    <= r1_x;
        r2_z    <= r1_z;
        r2_bad  <= r1_bad;
        r2_s    <= r1_xx + r1_zz;
        r2_l1sq <= r1_l1sq;
        r2_l2sq <= r1_l2sq;
    end

    // stage 3: numerators
    always_ff @(posedge i_clk) begin
        r3_x    <= r2_x;
        r3_z    <= r2_z;
        r3_bad  <= r2_bad;
        r3_s    <= r2_s;
        r3_l1sq <= r2_l1sq;
        r3_a1   <= $signed({3'b0, r2_l1sq}) + $signed({1'b0, r2_s}) - $signed({3'b0, r2_l2sq});
        r3_a2   <= $signed({3'b0, r2_l1sq}) + $signed({3'b0, r2_l2sq}) - $signed({1'b0, r2_s});
        r3_a3   <= $signed({3'b0, r2_l2sq}) + $signed({1'b0, r2_s}) - $signed({3'b0, r2_l1sq});
    end

    // stage 4: 4*l1^2*d^2 and a1^2
    always_comb begin
        n_prod = r3_l1sq * r3_s;
        n_a1sq = r3_a1 * r3_a1;
    end

    always_ff @(posedge i_clk) begin
        r4_x    <= r3_x;
        r4_z    <= r3_z;
        r4_bad  <= r3_bad;
        r4_a1   <= r3_a1;
        r4_a2   <= r3_a2;
        r4_a3   <= r3_a3;
        r4_p    <= {n_prod, 2'b00};
        r4_a1sq <= n_a1sq[59:0];
    end

    // stage 5: radicand, negative means out of reach
    assign n_h = $signed({1'b0, r4_p}) - $signed({1'b0, r4_a1sq});

    always_ff @(posedge i_clk) begin
        r5_x   <= r4_x;
        r5_z   <= r4_z;
        r5_a1  <= r4_a1;
        r5_a2  <= r4_a2;
        r5_a3  <= r4_a3;
        r5_bad <= r4_bad || n_h[60];
        r5_h   <= n_h[H_W-1:0];
    end

    assign o_valid     = r_v[FRONT_LAT-1];
    assign o_h         = r5_h;
    assign o_side.bad  = r5_bad;
    assign o_side.x    = r5_x;
    assign o_side.z    = r5_z;
    assign o_side.a1   = r5_a1;
    assign o_side.a2   = r5_a2;
    assign o_side.a3   = r5_a3;

endmodule
`default_nettype wire

>>> rtl/core/tlik_sqrt.sv
// Pipelined floor square root, one root bit per stage.
// Depends on tlik_pkg.
`default_nettype none
module tlik_sqrt
    import tlik_pkg::*;
(
    input  wire                  i_clk,
    input  wire                  i_rst_n,
    input  wire                  i_valid,
    input  wire  [H_W-1:0]       i_h,
    output logic                 o_valid,
    output logic [SQRT_BITS-1:0] o_root
);

    logic [SQRT_BITS-1:0] r_v;
    logic [H_W-1:0]       r_rem  [SQRT_BITS];
    logic [SQRT_BITS-1:0] r_root [SQRT_BITS];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else begin
            r_v <= {r_v[SQRT_BITS-2:0], i_valid};
        end
    end

    // stage j decides root bit k = SQRT_BITS-1-j
    for (genvar j = 0; j < SQRT_BITS; j++) begin : g_stage
        localparam int K = SQRT_BITS - 1 - j;
        logic [H_W-1:0]       w_rem;
        logic [SQRT_BITS-1:0] w_root;
        logic [61:0]          w_test;

        if (j == 0) begin : g_first
            assign w_rem  = i_h;
            assign w_root = '0;
        end else begin : g_rest
            assign w_rem  = r_rem[j-1];
            assign w_root = r_root[j-1];
        end

        // (r + 2^k)^2 - r^2 = r*2^(k+1) + 2^(2k)
        assign w_test = (62'(w_root) << (K + 1)) + (62'(1) << (2 * K));

        always_ff @(posedge i_clk) begin
            if ({2'b00, w_rem} >= w_test) begin
                r_rem[j]  <= H_W'({2'b00, w_rem} - w_test);
                r_root[j] <= w_root | (SQRT_BITS'(1) << K);
            end else begin
                r_rem[j]  <= w_rem;
                r_root[j] <= w_root;
            end
        end
    end

    assign o_valid = r_v[SQRT_BITS-1];
    assign o_root  = r_root[SQRT_BITS-1];

endmodule
`default_nettype wire

>>> rtl/core/tlik_cordic.sv
// Pipelined vectoring CORDIC: angle of (x, y) in 2^-14 degree.
// Depends on tlik_pkg.
`default_nettype none
module tlik_cordic
    import tlik_pkg::*;
(
    input  wire                  i_clk,
    input  wire                  i_rst_n,
    input  wire                  i_valid,
    input  wire  signed [CW-1:0] i_x,
    input  wire  signed [CW-1:0] i_y,
    output logic                 o_valid,
    output logic signed [AW-1:0] o_ang
);

    logic [CORDIC_LAT-1:0] r_v;
    logic signed [CW-1:0]  r_x   [CORDIC_LAT];
    logic signed [CW-1:0]  r_y   [CORDIC_LAT];
    logic signed [AW-1:0]  r_acc [CORDIC_LAT];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else begin
            r_v <= {r_v[CORDIC_LAT-2:0], i_valid};
        end
    end

    // pre-rotation into the right half plane
    always_ff @(posedge i_clk) begin
        if (i_x < 0 && i_y >= 0) begin
            r_x[0]   <= i_y;
            r_y[0]   <= -i_x;
            r_acc[0] <= ANG_DEG90;
        end else if (i_x < 0) begin
            r_x[0]   <= -i_y;
            r_y[0]   <= i_x;
            r_acc[0] <= -ANG_DEG90;
        end else begin
            r_x[0]   <= i_x;
            r_y[0]   <= i_y;
            r_acc[0] <= '0;
        end
    end

    // one micro-rotation per stage
    for (genvar i = 0; i < CORDIC_N; i++) begin : g_iter
        always_ff @(posedge i_clk) begin
            if (r_y[i] > 0) begin
                r_x[i+1]   <= r_x[i] + (r_y[i] >>> i);
                r_y[i+1]   <= r_y[i] - (r_x[i] >>> i);
                r_acc[i+1] <= r_acc[i] + atan_tab(i);
            end else begin
                r_x[i+1]   <= r_x[i] - (r_y[i] >>> i);
                r_y[i+1]   <= r_y[i] + (r_x[i] >>> i);
                r_acc[i+1] <= r_acc[i] - atan_tab(i);
            end
        end
    end

    assign o_valid = r_v[CORDIC_LAT-1];
    assign o_ang   = r_acc[CORDIC_LAT-1];

endmodule
`default_nettype wire

>>> rtl/core/two_link_leg_inverse_kinematics.sv
// Two-link leg IK: from start to o_done, 5 front stages, 30 root stages, 17 CORDIC stages and 1 output stage.
// Throughput one request per clock; busy stays low, the pipeline never stalls.
// The depth is dominated by the 30-stage bit-per-stage square root and the 17-stage CORDIC lanes.
// Synchronous active-low reset clears valid bits; lengths reset to 1280 (5 cm).
// Depends on tlik_pkg, tlik_front, tlik_sqrt, tlik_cordic and the defines header.
`default_nettype none
`include "two_link_leg_inverse_kinematics_defines.svh"
module two_link_leg_inverse_kinematics
    import tlik_pkg::*;
(
    input  wire                         i_clk,
    input  wire                         i_rst_n,
    input  wire                         start,
    output logic                        busy,
    input  wire  signed [POS_W-1:0]     i_foot_forward,
    input  wire  signed [POS_W-1:0]     i_foot_height,
    output logic                        o_done,
    output logic signed [ANG_OUT_W-1:0] o_hip_angle,
    output logic signed [ANG_OUT_W-1:0] o_knee_angle,
    output logic signed [ANG_OUT_W-1:0] o_ankle_angle,
    output logic                        o_unreachable,
    input  wire                         psel,
    input  wire                         penable,
    input  wire                         pwrite,
    input  wire  [2:0]                  paddr,
    input  wire  [31:0]                 pwdata,
    output logic [31:0]                 prdata,
    output logic                        pready
);

    logic [LEN_W-1:0] r_thigh, r_shin;
    t_reg_idx         w_idx;

    // configuration registers
    assign w_idx  = t_reg_idx'(paddr[2]);
    assign pready = 1'b1;
    assign busy   = 1'b0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_thigh <= LEN_RESET;
            r_shin  <= LEN_RESET;
        end else if (psel && penable && pwrite) begin
            case (w_idx)
                REG_THIGH: r_thigh <= pwdata[LEN_W-1:0];
                REG_SHIN:  r_shin  <= pwdata[LEN_W-1:0];
                default:   r_thigh <= r_thigh;
            endcase
        end
    end

    always_comb begin
        case (w_idx)
            REG_THIGH: prdata = {18'b0, r_thigh};
            REG_SHIN:  prdata = {18'b0, r_shin};
            default:   prdata = '0;
        endcase
    end

    // front: squares and radicand
    logic             f_valid;
    t_side            f_side;
    logic [H_W-1:0]   f_h;

    tlik_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (start && !busy),
        .i_x     (i_foot_forward),
        .i_z     (i_foot_height),
        .i_l1    (r_thigh),
        .i_l2    (r_shin),
        .o_valid (f_valid),
        .o_side  (f_side),
        .o_h     (f_h)
    );

    // square root of the radicand
    logic                 s_valid;
    logic [SQRT_BITS-1:0] s_root;

    tlik_sqrt u_sqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (f_valid),
        .i_h     (f_h),
        .o_valid (s_valid),
        .o_root  (s_root)
    );

    // side data delay matching the root
    t_side r_sd [SQRT_BITS];

    always_ff @(posedge i_clk) begin
        r_sd[0] <= f_side;
        for (int i = 1; i < SQRT_BITS; i++) begin
            r_sd[i] <= r_sd[i-1];
        end
    end

    t_side           w_sd;
    logic signed [CW-1:0] w_ry, w_hx, w_hy, w_a1, w_a2, w_a3;

    assign w_sd = r_sd[SQRT_BITS-1];
    assign w_ry = $signed({{(CW-SQRT_BITS-16){1'b0}}, s_root, 16'b0});
    assign w_hx = $signed({{(CW-POS_W-16){w_sd.z[POS_W-1]}}, w_sd.z, 16'b0});
    assign w_hy = $signed({{(CW-POS_W-16){w_sd.x[POS_W-1]}}, w_sd.x, 16'b0});
    assign w_a1 = $signed({{(CW-NUM_W-16){w_sd.a1[NUM_W-1]}}, w_sd.a1, 16'b0});
    assign w_a2 = $signed({{(CW-NUM_W-16){w_sd.a2[NUM_W-1]}}, w_sd.a2, 16'b0});
    assign w_a3 = $signed({{(CW-NUM_W-16){w_sd.a3[NUM_W-1]}}, w_sd.a3, 16'b0});

    // four CORDIC lanes
    logic                 c_valid;
    logic [2:0]           c_vu;
    logic signed [AW-1:0] c_hip2, c_t1, c_t2, c_t3;

    tlik_cordic u_cor_hip2 (
        .i_clk (i_clk), .i_rst_n (i_rst_n), .i_valid (s_valid),
        .i_x (w_hx), .i_y (w_hy), .o_valid (c_valid), .o_ang (c_hip2)
    );
    tlik_cordic u_cor_t1 (
        .i_clk (i_clk), .i_rst_n (i_rst_n), .i_valid (s_valid),
        .i_x (w_a1), .i_y (w_ry), .o_valid (c_vu[0]), .o_ang (c_t1)
    );
    tlik_cordic u_cor_t2 (
        .i_clk (i_clk), .i_rst_n (i_rst_n), .i_valid (s_valid),
        .i_x (w_a2), .i_y (w_ry), .o_valid (c_vu[1]), .o_ang (c_t2)
    );
    tlik_cordic u_cor_t3 (
        .i_clk (i_clk), .i_rst_n (i_rst_n), .i_valid (s_valid),
        .i_x (w_a3), .i_y (w_ry), .o_valid (c_vu[2]), .o_ang (c_t3)
    );

    // unreachable flag delay matching the CORDIC
    logic [CORDIC_LAT-1:0] r_bad;

    always_ff @(posedge i_clk) begin
        r_bad <= {r_bad[CORDIC_LAT-2:0], w_sd.bad};
    end

    // joint sums and rounding to 1/64 degree
    logic signed [SUM_W-1:0] n_hip, n_knee, n_ankle;
    logic                    r_done, r_unr;
    logic signed [ANG_OUT_W-1:0] r_hip, r_knee, r_ankle;

    always_comb begin
        n_hip   = SUM_W'(c_hip2) + SUM_W'(c_t1) + SUM_W'(128);
        n_knee  = SUM_W'(ANG_DEG180) - SUM_W'(c_t2) + SUM_W'(128);
        n_ankle = SUM_W'(ANG_DEG90) + SUM_W'(c_hip2) - SUM_W'(c_t3) + SUM_W'(128);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_done <= 1'b0;
        end else begin
            r_done <= c_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_unr <= r_bad[CORDIC_LAT-1];
        if (r_bad[CORDIC_LAT-1]) begin
            r_hip   <= '0;
            r_knee  <= '0;
            r_ankle <= '0;
        end else begin
            r_hip   <= n_hip[8 +: ANG_OUT_W];
            r_knee  <= n_knee[8 +: ANG_OUT_W];
            r_ankle <= n_ankle[8 +: ANG_OUT_W];
        end
    end

    assign o_done        = r_done;
    assign o_unreachable = r_unr;
    assign o_hip_angle   = r_hip;
    assign o_knee_angle  = r_knee;
    assign o_ankle_angle = r_ankle;

    // checks
    `TLIK_ASSERT_IMP(a_lanes_aligned, i_clk, i_rst_n, 1'b1, c_vu == {3{c_valid}})
    `TLIK_ASSERT_IMP(a_unr_zero, i_clk, i_rst_n, o_done && o_unreachable, o_hip_angle == 0 && o_knee_angle == 0 && o_ankle_angle == 0)
    `TLIK_ASSERT_IMP(a_knee_range, i_clk, i_rst_n, o_done && !o_unreachable, o_knee_angle >= -64 && o_knee_angle <= 11584)

endmodule
`default_nettype wire

>>> bench/tb_two_link_leg_inverse_kinematics.sv
// Self-checking bench for two_link_leg_inverse_kinematics: directed and random foot targets
// under several leg lengths, checked against an in-bench angle predictor.
// Depends on tlik_pkg and the RTL of the block.
`default_nettype none

// Holds the leg lengths, predicts joint angles and keeps the expected angle queue
class leg_angle_board;
    typedef struct {
        logic signed [15:0] hip;
        logic signed [15:0] knee;
        logic signed [15:0] ankle;
        logic               unreach;
    } angles_t;

    angles_t    pending_angles[$];
    logic [13:0] thigh_len;
    logic [13:0] shin_len;
    int         errors;
    longint     atan_lut[24];

    function new();
        thigh_len = tlik_pkg::LEN_RESET;
        shin_len  = tlik_pkg::LEN_RESET;
        errors    = 0;
        atan_lut = '{737280, 435242, 229970, 116736, 58595, 29326, 14667, 7334,
                     3667, 1833, 917, 458, 229, 115, 57, 29,
                     14, 7, 4, 2, 1, 0, 0, 0};
    endfunction

    function void set_length(tlik_pkg::t_reg_idx idx, logic [31:0] value);
        if (idx == tlik_pkg::REG_THIGH) thigh_len = value[13:0];
        else shin_len = value[13:0];
    endfunction

    // floor square root, bit by bit
    function longint unsigned floor_root(longint unsigned v);
        longint unsigned res, bitv;
        res = 0;
        bitv = 64'd1 << 62;
        while (bitv > v) bitv = bitv >> 2;
        while (bitv != 0) begin
            if (v >= res + bitv) begin
                v = v - (res + bitv);
                res = (res >> 1) + bitv;
            end else begin
                res = res >> 1;
            end
            bitv = bitv >> 2;
        end
        return res;
    endfunction

    // vectoring CORDIC, result in 2^-14 degree
    function longint vector_angle(longint vx, longint vy);
        longint acc, t, dx, dy;
        acc = 0;
        if (vx < 0) begin
            t = vx;
            if (vy >= 0) begin
                vx = vy; vy = -t; acc = 1474560;
            end else begin
                vx = -vy; vy = t; acc = -1474560;
            end
        end
        for (int i = 0; i < tlik_pkg::CORDIC_N; i++) begin
            dx = vy >>> i;
            dy = vx >>> i;
            if (vy > 0) begin
                vx += dx; vy -= dy; acc += atan_lut[i];
            end else begin
                vx -= dx; vy += dy; acc -= atan_lut[i];
            end
        end
        return acc;
    endfunction

    function logic signed [15:0] round_angle(longint v);
        longint r;
        r = (v + 128) >>> 8;
        return r[15:0];
    endfunction

    // accepted request: work out the joint angles
    function void note_target(logic signed [14:0] fx, logic signed [14:0] fz);
        angles_t e;
        longint x, z, l1, l2, s, l1sq, l2sq, a1, a2, a3, h, y, hip2, t1, t2, t3;
        x = fx; z = fz; l1 = thigh_len; l2 = shin_len;
        e = '{16'sd0, 16'sd0, 16'sd0, 1'b1};
        if (z > 0 && l1 != 0 && l2 != 0) begin
            s = x * x + z * z;
            l1sq = l1 * l1;
            l2sq = l2 * l2;
            a1 = l1sq + s - l2sq;
            a2 = l1sq + l2sq - s;
            a3 = l2sq + s - l1sq;
            h = 4 * l1sq * s - a1 * a1;
            if (h >= 0) begin
                y = longint'(floor_root(longint'(h)));
                hip2 = vector_angle(z * 65536, x * 65536);
                t1 = vector_angle(a1 * 65536, y * 65536);
                t2 = vector_angle(a2 * 65536, y * 65536);
                t3 = vector_angle(a3 * 65536, y * 65536);
                e.hip = round_angle(hip2 + t1);
                e.knee = round_angle(2949120 - t2);
                e.ankle = round_angle(1474560 + hip2 - t3);
                e.unreach = 1'b0;
            end
        end
        pending_angles.push_back(e);
    endfunction

    task report_mismatch(string what, longint got, longint want);
        $display("mismatch %s: got %0d expected %0d", what, got, want);
        errors++;
    endtask

    task check_angles(logic signed [15:0] hip, logic signed [15:0] knee,
                      logic signed [15:0] ankle, logic unreach);
        angles_t e;
        if (pending_angles.size() == 0) begin
            report_mismatch("unexpected result", 1, 0);
        end else begin
            e = pending_angles.pop_front();
            if (hip !== e.hip) report_mismatch("hip_angle", hip, e.hip);
            if (knee !== e.knee) report_mismatch("knee_angle", knee, e.knee);
            if (ankle !== e.ankle) report_mismatch("ankle_angle", ankle, e.ankle);
            if (unreach !== e.unreach) report_mismatch("unreachable", unreach, e.unreach);
        end
    endtask
endclass

module tb_two_link_leg_inverse_kinematics;
    import tlik_pkg::*;

    logic                        i_clk = 1'b0;
    logic                        i_rst_n = 1'b0;
    logic                        start = 1'b0;
    logic                        busy;
    logic signed [POS_W-1:0]     i_foot_forward = '0;
    logic signed [POS_W-1:0]     i_foot_height = '0;
    logic                        o_done;
    logic signed [ANG_OUT_W-1:0] o_hip_angle, o_knee_angle, o_ankle_angle;
    logic                        o_unreachable;
    logic                        psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
    logic [2:0]                  paddr = '0;
    logic [31:0]                 pwdata = '0;
    logic [31:0]                 prdata;
    logic                        pready;

    leg_angle_board board = new();
    int idle_pct = 0;
    int sent = 0;

    two_link_leg_inverse_kinematics dut (.*);

    always #6 i_clk = ~i_clk;

    // record accepted requests and check every done strobe
    always @(posedge i_clk) begin
        if (i_rst_n && start && !busy) board.note_target(i_foot_forward, i_foot_height);
        if (i_rst_n && o_done)
            board.check_angles(o_hip_angle, o_knee_angle, o_ankle_angle, o_unreachable);
    end

    // one request; returns once it has been taken, then idles cycle by cycle
    task send_target(logic signed [POS_W-1:0] fx, logic signed [POS_W-1:0] fz);
        start <= 1'b1;
        i_foot_forward <= fx;
        i_foot_height <= fz;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
        sent++;
        while ($urandom_range(99) < idle_pct) begin
            start <= 1'b0;
            @(posedge i_clk);
        end
    endtask

    // stop sending and let the pipeline empty
    task drain();
        start <= 1'b0;
        while (board.pending_angles.size() != 0) @(posedge i_clk);
        repeat (FRONT_LAT + SQRT_BITS + CORDIC_LAT + 4) @(posedge i_clk);
    endtask

    task write_length(t_reg_idx idx, logic [31:0] value);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 2'b00};
        pwdata <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        board.set_length(idx, value);
    endtask

    // mostly targets inside the leg's reach, some anywhere
    task random_targets(int count);
        int reach, fx, fz;
        for (int n = 0; n < count; n++) begin
            idle_pct = (sent < 530) ? 28 : (sent < 1060) ? 81 : 0;
            reach = board.thigh_len + board.shin_len + 2;
            if (reach > 16383) reach = 16383;
            if ($urandom_range(9) < 7) begin
                fx = $urandom_range(2 * reach) - reach;
                fz = $urandom_range(reach, 1);
                if (fx < -16384) fx = -16384;
                send_target(fx[POS_W-1:0], fz[POS_W-1:0]);
            end else begin
                send_target(POS_W'($urandom()), POS_W'($urandom()));
            end
        end
    endtask

    initial begin
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: field extremes, height not positive, reach boundaries
        idle_pct = 0;
        send_target(15'sd0, 15'sd2560);          // outer boundary, leg straight
        send_target(15'sd0, 15'sd2561);          // just beyond reach
        send_target(15'sd1000, 15'sd1500);
        send_target(-15'sd1000, 15'sd1500);
        send_target(15'sd0, 15'sd0);
        send_target(15'sd100, -15'sd100);
        send_target(-15'sd16384, -15'sd16384);
        send_target(15'sd16383, 15'sd16383);
        send_target(15'sd0, 15'sd1);             // d = 0 region, inner boundary
        send_target(15'sd1810, 15'sd1810);
        drain();
        // extreme lengths, upper bits of the data must be dropped
        write_length(REG_THIGH, 32'hFFFF_FFFF);
        write_length(REG_SHIN, 32'h0000_3FFF);
        send_target(-15'sd16384, 15'sd16383);
        send_target(15'sd16383, 15'sd1);
        send_target(15'sd0, 15'sd16383);
        send_target(15'sd0, 15'sd1);
        random_targets(250);
        drain();
        write_length(REG_THIGH, 32'd1);
        write_length(REG_SHIN, 32'd1);
        send_target(15'sd0, 15'sd2);
        send_target(15'sd1, 15'sd1);
        random_targets(250);
        drain();
        // zero length and unequal legs with an inner boundary
        write_length(REG_THIGH, 32'd0);
        send_target(15'sd0, 15'sd100);
        random_targets(40);
        drain();
        write_length(REG_THIGH, 32'd1280);
        write_length(REG_SHIN, 32'd256);
        send_target(15'sd0, 15'sd1024);
        send_target(15'sd0, 15'sd1023);
        send_target(15'sd0, 15'sd1536);
        random_targets(300);
        drain();
        write_length(REG_SHIN, 32'd0);
        random_targets(40);
        drain();
        write_length(REG_THIGH, 32'd3000);
        write_length(REG_SHIN, 32'd700);
        random_targets(300);
        drain();
        write_length(REG_THIGH, $urandom_range(16383, 1));
        write_length(REG_SHIN, $urandom_range(16383, 1));
        random_targets(400);
        drain();

        if (board.errors == 0 && board.pending_angles.size() == 0)
            $display("** two_link_leg_inverse_kinematics: PASSED **");
        else
            $display("** two_link_leg_inverse_kinematics: FAILED **");
        $finish;
    end

    // watchdog
    initial begin
        #(12 * 400000);
        $display("** two_link_leg_inverse_kinematics: FAILED **");
        $finish;
    end
endmodule
`default_nettype wire

>>> sim.f
+incdir+rtl/core
rtl/core/tlik_pkg.sv
rtl/core/tlik_front.sv
rtl/core/tlik_sqrt.sv
rtl/core/tlik_cordic.sv
rtl/core/two_link_leg_inverse_kinematics.sv
bench/tb_two_link_leg_inverse_kinematics.sv
